// ----- rtl/lvp_pkg.sv -----
package lvp_pkg;

  // Longest stored line, in content bytes plus one
  localparam int LINE_BYTES = 64;
  localparam int CntW       = $clog2(LINE_BYTES);
  localparam logic [CntW-1:0] CntMax = CntW'(LINE_BYTES - 1);

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChVt    = 8'h0B;
  localparam logic [7:0] ChFf    = 8'h0C;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChC     = 8'h43;
  localparam logic [7:0] ChI     = 8'h49;
  localparam logic [7:0] ChN     = 8'h4E;
  localparam logic [7:0] ChO     = 8'h4F;
  localparam logic [7:0] ChP     = 8'h50;
  localparam logic [7:0] ChS     = 8'h53;
  localparam logic [7:0] ChV     = 8'h56;

  // Saturation bounds: floor((limit - d) / 10) takes one of two values
  localparam logic [31:0] DecQuotHi = 32'd214748364;
  localparam logic [31:0] DecQuotLo = 32'd214748363;
  localparam logic [31:0] PosLimit  = 32'h7FFF_FFFF;
  localparam logic [31:0] NegLimit  = 32'h8000_0000;

  typedef enum logic [2:0] {
    PH_BEFORE_LABEL = 3'd0,
    PH_LABEL        = 3'd1,
    PH_BEFORE_VALUE = 3'd2,
    PH_VALUE        = 3'd3,
    PH_AFTER_VALUE  = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    QTY_V   = 3'd0,
    QTY_I   = 3'd1,
    QTY_P   = 3'd2,
    QTY_SOC = 3'd3,
    QTY_VS  = 3'd4
  } quantity_e;

  typedef struct packed {
    logic vs;
    logic soc;
    logic p;
    logic i;
    logic v;
  } label_match_t;

  typedef struct packed {
    logic stop;
    logic digits;
    logic neg;
    logic sgn;
    logic oword;
  } value_flags_t;

  typedef struct packed {
    value_flags_t flags;
    logic [31:0]  acc;
  } value_state_t;

endpackage

// ----- rtl/lvp_in_if.sv -----
interface lvp_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  rx_byte;
  logic [31:0] now_ms;

  modport source (output valid, output rx_byte, output now_ms, input ready);
  modport sink   (input valid, input rx_byte, input now_ms, output ready);
endinterface

// ----- rtl/lvp_out_if.sv -----
interface lvp_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         quantity;
  logic signed [31:0] reading;
  logic [31:0]        stamp_ms;

  modport source (output valid, output quantity, output reading, output stamp_ms,
                  input ready);
  modport sink   (input valid, input quantity, input reading, input stamp_ms,
                  output ready);
endinterface

// ----- rtl/label_value_line_parser.sv -----
// Line parser for tab-separated label/value text. One byte is taken per clock
// cycle, sustained, as long as the result side keeps up; a byte is held in an
// input register, is parsed there against the line state, and an LF that
// closes a V, I, P, SOC or VS line loads the result register, so a result is
// valid once the LF has passed the input register and the result register.
// Both the input register and the result register hold while the result side
// stalls, and input transfers continue until both are full. There is no
// clearing pass after reset: the block takes bytes from the first cycle.
module label_value_line_parser (
  input  logic      clk_i,
  input  logic      rst_ni,
  lvp_in_if.sink    in_i,
  lvp_out_if.source out_o
);

  // Input register
  logic        stage_valid_q;
  logic [7:0]  stage_byte_q;
  logic [31:0] stage_stamp_q;

  // Line state
  logic [lvp_pkg::CntW-1:0] count_q, count_d;
  lvp_pkg::phase_e          phase_q, phase_d;
  lvp_pkg::label_match_t    match_q, match_d;
  logic [1:0]               label_len_q, label_len_d;
  lvp_pkg::value_state_t    val_q, val_d;
  logic                     discard_q, discard_d;
  logic                     ended_q, ended_d;

  // Result register
  logic               out_valid_q;
  logic [2:0]         out_qty_q;
  logic signed [31:0] out_reading_q;
  logic [31:0]        out_stamp_q;

  logic               out_free;
  logic               advance;
  logic               res_valid;
  logic [2:0]         res_qty;
  logic [31:0]        res_reading;

  function automatic lvp_pkg::label_match_t label_step(
    lvp_pkg::label_match_t m, logic [1:0] len, logic [7:0] c);
    lvp_pkg::label_match_t keep;
    keep = '0;
    case (len)
      2'd0: begin
        keep.v   = (c == lvp_pkg::ChV);
        keep.vs  = (c == lvp_pkg::ChV);
        keep.i   = (c == lvp_pkg::ChI);
        keep.p   = (c == lvp_pkg::ChP);
        keep.soc = (c == lvp_pkg::ChS);
      end
      2'd1: begin
        keep.soc = (c == lvp_pkg::ChO);
        keep.vs  = (c == lvp_pkg::ChS);
      end
      2'd2: begin
        keep.soc = (c == lvp_pkg::ChC);
      end
      default: ;
    endcase
    return m & keep;
  endfunction

  function automatic logic [31:0] add_digit(logic [31:0] acc, logic neg, logic [3:0] d);
    logic [31:0] lim;
    logic [31:0] thr;
    lim = neg ? lvp_pkg::NegLimit : lvp_pkg::PosLimit;
    thr = (neg ? (d == 4'd9) : (d >= 4'd8)) ? lvp_pkg::DecQuotLo : lvp_pkg::DecQuotHi;
    if (acc > thr) begin
      return lim;
    end
    return (acc << 3) + (acc << 1) + {28'd0, d};
  endfunction

  function automatic lvp_pkg::value_state_t value_step(
    lvp_pkg::value_state_t v, logic first, logic [7:0] c);
    lvp_pkg::value_state_t r;
    logic       digit;
    logic [3:0] d;
    logic [7:0] diff;
    r     = v;
    digit = (c >= lvp_pkg::ChZero) && (c <= lvp_pkg::ChNine);
    diff  = c - lvp_pkg::ChZero;
    d     = diff[3:0];
    if (first && c == lvp_pkg::ChO) begin
      r.flags       = '0;
      r.flags.oword = 1'b1;
    end else if (v.flags.stop) begin
      r = v;
    end else if (v.flags.oword) begin
      r.acc        = {31'd0, c == lvp_pkg::ChN};
      r.flags.stop = 1'b1;
    end else if (v.flags.digits || v.flags.sgn) begin
      if (digit) begin
        r.flags.digits = 1'b1;
        r.acc          = add_digit(v.acc, v.flags.neg, d);
      end else begin
        r.flags.stop = 1'b1;
      end
    end else if (c == lvp_pkg::ChSpace || c == lvp_pkg::ChVt || c == lvp_pkg::ChFf) begin
      r = v;
    end else if (c == lvp_pkg::ChPlus || c == lvp_pkg::ChMinus) begin
      r.flags.sgn = 1'b1;
      r.flags.neg = (c == lvp_pkg::ChMinus);
    end else if (digit) begin
      r.flags.digits = 1'b1;
      r.acc          = add_digit(v.acc, v.flags.neg, d);
    end else begin
      r.flags.stop = 1'b1;
    end
    return r;
  endfunction

  assign out_free  = !out_valid_q || out_o.ready;
  assign advance   = stage_valid_q && out_free;
  assign in_i.ready = !stage_valid_q || out_free;

  always_comb begin
    count_d     = count_q;
    phase_d     = phase_q;
    match_d     = match_q;
    label_len_d = label_len_q;
    val_d       = val_q;
    discard_d   = discard_q;
    ended_d     = ended_q;
    res_valid   = 1'b0;
    res_qty     = lvp_pkg::QTY_V;
    res_reading = val_q.acc;

    if (val_q.flags.neg && !val_q.flags.oword) begin
      res_reading = 32'd0 - val_q.acc;
    end

    if (label_len_q == 2'd1 && match_q.v) begin
      res_qty   = lvp_pkg::QTY_V;
      res_valid = 1'b1;
    end else if (label_len_q == 2'd1 && match_q.i) begin
      res_qty   = lvp_pkg::QTY_I;
      res_valid = 1'b1;
    end else if (label_len_q == 2'd1 && match_q.p) begin
      res_qty   = lvp_pkg::QTY_P;
      res_valid = 1'b1;
    end else if (label_len_q == 2'd3 && match_q.soc) begin
      res_qty   = lvp_pkg::QTY_SOC;
      res_valid = 1'b1;
    end else if (label_len_q == 2'd2 && match_q.vs) begin
      res_qty   = lvp_pkg::QTY_VS;
      res_valid = 1'b1;
    end
    res_valid = res_valid && !discard_q && stage_byte_q == lvp_pkg::ChLf &&
                (phase_q == lvp_pkg::PH_VALUE || phase_q == lvp_pkg::PH_AFTER_VALUE);

    if (stage_byte_q == lvp_pkg::ChCr) begin
      count_d = count_q;
    end else if (stage_byte_q == lvp_pkg::ChLf || count_q >= lvp_pkg::CntMax) begin
      // End of line, or overflow: start over; overflow drops up to the LF
      count_d     = '0;
      phase_d     = lvp_pkg::PH_BEFORE_LABEL;
      match_d     = '1;
      label_len_d = 2'd0;
      val_d       = '0;
      ended_d     = 1'b0;
      discard_d   = (stage_byte_q != lvp_pkg::ChLf) && !discard_q ? 1'b1 :
                    (stage_byte_q != lvp_pkg::ChLf) && discard_q;
      if (discard_q && stage_byte_q != lvp_pkg::ChLf) begin
        count_d = count_q;
      end
    end else if (!discard_q) begin
      count_d = count_q + lvp_pkg::CntW'(1);
      if (stage_byte_q == lvp_pkg::ChNul) begin
        ended_d = 1'b1;
      end else if (!ended_q) begin
        case (phase_q)
          lvp_pkg::PH_BEFORE_LABEL: begin
            if (stage_byte_q != lvp_pkg::ChTab) begin
              phase_d     = lvp_pkg::PH_LABEL;
              match_d     = label_step(match_q, label_len_q, stage_byte_q);
              label_len_d = label_len_q + 2'd1;
            end
          end
          lvp_pkg::PH_LABEL: begin
            if (stage_byte_q == lvp_pkg::ChTab) begin
              phase_d = lvp_pkg::PH_BEFORE_VALUE;
            end else begin
              match_d = label_step(match_q, label_len_q, stage_byte_q);
              if (label_len_q != 2'd3) begin
                label_len_d = label_len_q + 2'd1;
              end
            end
          end
          lvp_pkg::PH_BEFORE_VALUE: begin
            if (stage_byte_q != lvp_pkg::ChTab) begin
              phase_d = lvp_pkg::PH_VALUE;
              val_d   = value_step(val_q, 1'b1, stage_byte_q);
            end
          end
          lvp_pkg::PH_VALUE: begin
            if (stage_byte_q == lvp_pkg::ChTab) begin
              phase_d = lvp_pkg::PH_AFTER_VALUE;
            end else begin
              val_d = value_step(val_q, 1'b0, stage_byte_q);
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      stage_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      stage_byte_q  <= in_i.rx_byte;
      stage_stamp_q <= in_i.now_ms;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      phase_q     <= lvp_pkg::PH_BEFORE_LABEL;
      match_q     <= '1;
      label_len_q <= 2'd0;
      val_q       <= '0;
      discard_q   <= 1'b0;
      ended_q     <= 1'b0;
    end else if (advance) begin
      count_q     <= count_d;
      phase_q     <= phase_d;
      match_q     <= match_d;
      label_len_q <= label_len_d;
      val_q       <= val_d;
      discard_q   <= discard_d;
      ended_q     <= ended_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_qty_q     <= res_qty;
      out_reading_q <= res_reading;
      out_stamp_q   <= stage_stamp_q;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.quantity = out_qty_q;
  assign out_o.reading  = out_reading_q;
  assign out_o.stamp_ms = out_stamp_q;

  // A new result comes only from a parsed LF
  a_result_from_lf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(stage_valid_q && stage_byte_q == lvp_pkg::ChLf))
    else $error("result without a line feed");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= lvp_pkg::CntMax)
    else $error("line byte count past limit");

  a_discard_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    discard_q |-> (phase_q == lvp_pkg::PH_BEFORE_LABEL && count_q == '0))
    else $error("line state not cleared while dropping");

  a_oword_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    val_q.flags.oword |-> !(val_q.flags.digits || val_q.flags.sgn))
    else $error("O-word mixed with numeric value");

endmodule
